// File: rtl/core/spfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfr_pkg
// Shared types, register codes and tables for the stream find/replace unit.
// ----------------------------------------------------------------------------
package spfr_pkg;

    localparam int unsigned MAX_PATTERN_BYTES_DEF = 16;
    localparam int unsigned CFG_INDEX_W           = 3;
    localparam int unsigned CFG_DATA_W            = 64;
    localparam int unsigned HIT_W                 = 16;
    localparam int unsigned PHASE_W               = 4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FIND_LOW       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIND_HIGH      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACE_LOW    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACE_HIGH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_STRIDE   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_HITS  = 3'd6;

    // match_status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_OVER  = 2'd1;
    localparam logic [1:0] STATUS_FEWER = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             out_last;
        logic [HIT_W-1:0] hit_count;
        logic [1:0]       match_status;
    } out_t;

    typedef struct packed {
        logic [63:0]      find_low;
        logic [63:0]      find_high;
        logic [63:0]      replace_low;
        logic [63:0]      replace_high;
        logic [4:0]       pattern_length;
        logic [4:0]       match_stride;
        logic [HIT_W-1:0] expected_hits;
    } cfg_t;

    typedef struct packed {
        logic fire;      // engine performs one step this cycle
        logic take_new;  // that step starts with the held input byte
    } eng_ctl_t;

    // Row s-1 holds p % s in nibble p, p = 0..15.
    localparam logic [63:0] PHASE_MOD_TABLE [16] = '{
        64'h0000_0000_0000_0000,
        64'h1010_1010_1010_1010,
        64'h0210_2102_1021_0210,
        64'h3210_3210_3210_3210,
        64'h0432_1043_2104_3210,
        64'h3210_5432_1054_3210,
        64'h1065_4321_0654_3210,
        64'h7654_3210_7654_3210,
        64'h6543_2108_7654_3210,
        64'h5432_1098_7654_3210,
        64'h4321_0A98_7654_3210,
        64'h3210_BA98_7654_3210,
        64'h210C_BA98_7654_3210,
        64'h10DC_BA98_7654_3210,
        64'h0EDC_BA98_7654_3210,
        64'hFEDC_BA98_7654_3210
    };

    function automatic logic [PHASE_W-1:0] phase_mod(
        input logic [PHASE_W-1:0] phase,
        input logic [PHASE_W-1:0] stride_m1
    );
        logic [63:0] row;
        row = PHASE_MOD_TABLE[stride_m1];
        return row[{phase, 2'b00} +: PHASE_W];
    endfunction

endpackage

// File: rtl/core/spfr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfr_cfg_regs
// Configuration register file; one write per transfer, unknown indexes ignored.
// ----------------------------------------------------------------------------
module spfr_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [spfr_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  logic [spfr_pkg::CFG_DATA_W-1:0]    wr_data,
    output spfr_pkg::cfg_t                     cfg
);
    import spfr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_FIND_LOW:       cfg_next.find_low       = wr_data;
                CFG_FIND_HIGH:      cfg_next.find_high      = wr_data;
                CFG_REPLACE_LOW:    cfg_next.replace_low    = wr_data;
                CFG_REPLACE_HIGH:   cfg_next.replace_high   = wr_data;
                CFG_PATTERN_LENGTH: cfg_next.pattern_length = wr_data[4:0];
                CFG_MATCH_STRIDE:   cfg_next.match_stride   = wr_data[4:0];
                CFG_EXPECTED_HITS:  cfg_next.expected_hits  = wr_data[HIT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.find_low       <= '0;
            cfg_reg.find_high      <= '0;
            cfg_reg.replace_low    <= '0;
            cfg_reg.replace_high   <= '0;
            cfg_reg.pattern_length <= 5'd4;
            cfg_reg.match_stride   <= 5'd1;
            cfg_reg.expected_hits  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/spfr_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfr_engine
// Byte window, parallel compare/patch and hit bookkeeping; at most one byte out per step.
// ----------------------------------------------------------------------------
module spfr_engine #(
    parameter int unsigned MAX_BYTES = spfr_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  spfr_pkg::eng_ctl_t  ctl,
    input  spfr_pkg::in_t       item,
    input  spfr_pkg::cfg_t      cfg,
    output logic                emit,
    output spfr_pkg::out_t      result,
    output logic                busy
);
    import spfr_pkg::*;

    localparam int unsigned FILL_W = $clog2(MAX_BYTES + 1);

    logic [7:0]         win_reg   [MAX_BYTES];
    logic [7:0]         win_next  [MAX_BYTES];
    logic [7:0]         win_base  [MAX_BYTES];
    logic [7:0]         win_patch [MAX_BYTES];
    logic [FILL_W-1:0]  fill_reg, fill_next, fill_base;
    logic [PHASE_W-1:0] phase_reg, phase_next, phase_base, phase_inc;
    logic [HIT_W-1:0]   hits_reg, hits_next, hits_new;
    logic               ovr_reg, ovr_next, ovr_new;
    logic               chk_reg, chk_next, chk_base;
    logic               lst_reg, lst_next, lst_base;

    logic [FILL_W-1:0]  len_eff;
    logic [PHASE_W-1:0] stride_m1;
    logic [127:0]       find_all, repl_all;
    logic               eq_all, over_len, do_check, hit, final_byte;

    assign find_all = {cfg.find_high, cfg.find_low};
    assign repl_all = {cfg.replace_high, cfg.replace_low};

    // Out-of-range length and stride settings clamp to the legal range
    always_comb
    begin
        if (cfg.pattern_length == '0)
            len_eff = FILL_W'(1);
        else if (cfg.pattern_length > 5'(MAX_BYTES))
            len_eff = FILL_W'(MAX_BYTES);
        else
            len_eff = FILL_W'(cfg.pattern_length);

        if (cfg.match_stride == '0)
            stride_m1 = '0;
        else if (cfg.match_stride > 5'd16)
            stride_m1 = '1;
        else
            stride_m1 = PHASE_W'(cfg.match_stride - 5'd1);
    end

    // Window after the optional append, then compare and patch
    always_comb
    begin
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            if (ctl.take_new && fill_reg == FILL_W'(i))
                win_base[i] = item.data_byte;
            else
                win_base[i] = win_reg[i];
        end
        fill_base  = ctl.take_new ? fill_reg + FILL_W'(1) : fill_reg;
        chk_base   = ctl.take_new | chk_reg;
        lst_base   = ctl.take_new ? item.last_byte : lst_reg;
        phase_base = ctl.take_new ? phase_mod(phase_reg, stride_m1) : phase_reg;

        eq_all = 1'b1;
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            if (FILL_W'(i) < len_eff && win_base[i] != find_all[8*i +: 8])
                eq_all = 1'b0;
        end

        over_len = fill_base > len_eff;
        do_check = !over_len && fill_base == len_eff && chk_base;
        hit      = do_check && !ovr_reg && phase_base == '0 && eq_all;
        emit     = over_len || do_check || (lst_base && fill_base != '0);

        for (int i = 0; i < MAX_BYTES; i++)
        begin
            if (hit && FILL_W'(i) < len_eff)
                win_patch[i] = repl_all[8*i +: 8];
            else
                win_patch[i] = win_base[i];
        end

        hits_new   = (hit && hits_reg != '1) ? hits_reg + HIT_W'(1) : hits_reg;
        ovr_new    = ovr_reg || (hit && cfg.expected_hits != '0
                                 && hits_new > cfg.expected_hits);
        final_byte = lst_base && emit && fill_base == FILL_W'(1);
        phase_inc  = (phase_base == stride_m1) ? '0 : phase_base + PHASE_W'(1);
    end

    // Result fields
    always_comb
    begin
        result.out_byte  = win_patch[0];
        result.out_last  = final_byte;
        result.hit_count = hits_new;
        if (ovr_new)
            result.match_status = STATUS_OVER;
        else if (final_byte && cfg.expected_hits != '0 && hits_new < cfg.expected_hits)
            result.match_status = STATUS_FEWER;
        else
            result.match_status = STATUS_OK;
    end

    // Next state
    always_comb
    begin
        for (int i = 0; i < MAX_BYTES - 1; i++)
        begin
            if (emit)
                win_next[i] = win_patch[i + 1];
            else
                win_next[i] = win_patch[i];
        end
        win_next[MAX_BYTES-1] = win_patch[MAX_BYTES-1];
        fill_next  = emit ? fill_base - FILL_W'(1) : fill_base;
        phase_next = emit ? phase_inc : phase_base;
        hits_next  = hits_new;
        ovr_next   = ovr_new;
        chk_next   = chk_base && over_len;
        lst_next   = lst_base;
        if (final_byte)
        begin
            fill_next  = '0;
            phase_next = '0;
            hits_next  = '0;
            ovr_next   = 1'b0;
            chk_next   = 1'b0;
            lst_next   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fire)
        begin
            for (int i = 0; i < MAX_BYTES; i++)
                win_reg[i] <= win_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            phase_reg <= '0;
            hits_reg  <= '0;
            ovr_reg   <= 1'b0;
            chk_reg   <= 1'b0;
            lst_reg   <= 1'b0;
        end
        else if (ctl.fire)
        begin
            fill_reg  <= fill_next;
            phase_reg <= phase_next;
            hits_reg  <= hits_next;
            ovr_reg   <= ovr_next;
            chk_reg   <= chk_next;
            lst_reg   <= lst_next;
        end
    end

    // Work left from an earlier byte: over-length drain or end-of-image flush
    assign busy = chk_reg || (lst_reg && fill_reg != '0);

endmodule

// File: rtl/core/stream_pattern_find_replace_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_pattern_find_replace_unit
// Streaming byte find-and-replace with hit counting and count checking.
// ----------------------------------------------------------------------------
// Usage:
//   byte_*   : input image, one byte per transfer, last_byte on the final one.
//   result_* : output image, one byte per transfer, with running hit_count
//              and match_status; out_last marks the final byte.
//   cfg_*    : register writes (index 0..6), always ready; write only while
//              no byte is in flight.
// Release: a byte leaves once pattern_length - 1 later bytes have arrived (or
//   at the image end); the completing byte is held in the input register and
//   the result is registered in the output register before its transfer.
// Throughput: one byte per cycle in steady state unless result_ready stalls it.
//   The single window engine emits at most one byte per cycle, so after the last
//   byte each held byte (up to pattern_length - 1) is flushed in its own step,
//   and shortening the pattern mid-image drains the surplus the same way.
// Reset: counters, status and handshake state clear; registers return to
//   length 4, stride 1, all patterns zero, count checking off.
// Stall: while result_valid is high and result_ready is low the output register
//   holds, the engine stops, and byte_ready drops once the input register is occupied.
// ----------------------------------------------------------------------------
module stream_pattern_find_replace_unit #(
    parameter int unsigned MAX_PATTERN_BYTES = spfr_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [spfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [spfr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               byte_valid,
    output logic                               byte_ready,
    input  spfr_pkg::in_t                      byte_data,
    output logic                               result_valid,
    input  logic                               result_ready,
    output spfr_pkg::out_t                     result_data
);
    import spfr_pkg::*;

    cfg_t     cfg;
    eng_ctl_t eng_ctl;
    out_t     eng_result;
    logic     eng_emit;
    logic     eng_busy;

    in_t      item_reg;
    logic     item_valid_reg;
    out_t     result_reg;
    logic     result_valid_reg;
    logic     result_valid_next;
    logic     adv;

    // Registers accept every write immediately
    assign cfg_ready = 1'b1;

    spfr_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Engine steps when it has work and the output register can take its result.
    // Pending drain/flush work has priority over the held input byte.
    assign adv              = !result_valid_reg || result_ready;
    assign eng_ctl.take_new = adv && !eng_busy && item_valid_reg;
    assign eng_ctl.fire     = adv && (eng_busy || item_valid_reg);
    assign byte_ready       = !item_valid_reg || eng_ctl.take_new;

    spfr_engine #(
        .MAX_BYTES (MAX_PATTERN_BYTES)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (eng_ctl),
        .item   (item_reg),
        .cfg    (cfg),
        .emit   (eng_emit),
        .result (eng_result),
        .busy   (eng_busy)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (byte_valid && byte_ready)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (eng_ctl.take_new)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
            item_reg <= byte_data;
    end

    // Output register
    assign result_valid_next = eng_ctl.fire && eng_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && result_valid_next)
            result_reg <= eng_result;
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

`ifndef SYNTHESIS
    // A drain or flush step always produces a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        eng_busy && adv |=> result_valid_reg)
        else $error("drain step produced no output byte");

    // Short-count status only on the final byte of an image
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.match_status == STATUS_FEWER |-> result_reg.out_last)
        else $error("fewer-hits status on a non-final byte");

    // After the final byte is produced no work remains for that image
    assert property (@(posedge clk) disable iff (!rst_n)
        eng_ctl.fire && eng_emit && eng_result.out_last |=> !eng_busy)
        else $error("engine still busy after end of image");
`endif

endmodule
